### rtl/sae_pkg.sv
// Shared types and constants for the stack allocator engine.
package sae_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_RESIZE   = 2'd1,
        OP_FREE     = 2'd2,
        OP_FREE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_OOM    = 3'd1;
    localparam logic [2:0] ST_BOUNDS = 3'd2;
    localparam logic [2:0] ST_ABOVE  = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;

    localparam logic [1:0] CFG_BUFFER_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_BASE_LOW_BITS  = 2'd1;
    localparam logic [1:0] CFG_ALIGNMENT_LOG2 = 2'd2;

    localparam int PAD_W = 8;

endpackage

### rtl/stack_allocator_engine_top.sv
// Stack allocator engine: allocation state machine with a header memory.
//
// Each transaction has an accept step and an execute step: the accept step
// (S_IDLE) computes the alignment padding from the current top offset and
// issues the synchronous header read, the execute step (S_EXEC) does the
// alloc, free or resize decision, writes the header back and loads the
// result register. The single header memory port pair and the dependence of
// every request on the updated top offset allow one transaction at a time. A
// result waiting at the output holds the execute step only; the input side is
// open again as soon as the result is loaded. The header memory needs no
// clearing pass after reset; configuration writes are taken in every cycle.
module stack_allocator_engine_top
    import sae_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096,
    parameter int HEADER_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [12:0] request_size,
    input  logic [12:0] current_size,
    input  logic [11:0] block_offset,
    input  logic        block_present,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        result_valid,
    output logic [11:0] result_offset,
    output logic [11:0] copy_source,
    output logic [12:0] copy_length
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int XW = ((AW > 13) ? AW : 13) + 1;
    localparam int HW = PAD_W + XW;

    // configuration
    logic [12:0] buffer_length_reg;
    logic [6:0]  base_low_bits_reg;
    logic [2:0]  alignment_log2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg  <= 13'd4096;
            base_low_bits_reg  <= 7'd0;
            alignment_log2_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BUFFER_LENGTH:  buffer_length_reg  <= cfg_data;
                CFG_BASE_LOW_BITS:  base_low_bits_reg  <= cfg_data[6:0];
                CFG_ALIGNMENT_LOG2: alignment_log2_reg <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    // control and allocator state
    state_t         state_reg, state_next;
    logic [XW-1:0]  top_reg, top_next;
    logic [XW-1:0]  prev_reg, prev_next;

    // latched request
    op_t            op_reg;
    logic [12:0]    req_reg;
    logic [12:0]    old_reg;
    logic [11:0]    blk_reg;
    logic           present_reg;
    logic [PAD_W-1:0] pad_reg;

    // result register
    logic           out_valid_reg, out_valid_next;
    logic [2:0]     status_reg, status_next;
    logic           rvalid_reg, rvalid_next;
    logic [11:0]    roffset_reg, roffset_next;
    logic [11:0]    csrc_reg, csrc_next;
    logic [12:0]    clen_reg, clen_next;

    // header memory
    logic [HW-1:0]  hdr_mem [BUFFER_BYTES];
    logic [HW-1:0]  hdr_rdata_reg;
    logic           hdr_we;
    logic [AW-1:0]  hdr_waddr;
    logic [HW-1:0]  hdr_wdata;

    logic           in_accept;
    logic           advance;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign advance   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // padding from the current top, computed while idle
    logic [8:0] amask;
    logic [7:0] mod_sum;
    logic [6:0] mod_val;
    logic [8:0] pad0;
    logic [8:0] need;
    logic [8:0] pad_full;

    always_comb
    begin
        amask    = (9'd1 << alignment_log2_reg) - 9'd1;
        mod_sum  = {1'b0, base_low_bits_reg} + {1'b0, top_reg[6:0]};
        mod_val  = mod_sum[6:0] & amask[6:0];
        pad0     = (mod_val != 7'd0) ? (amask + 9'd1 - {2'b00, mod_val}) : 9'd0;
        need     = 9'(HEADER_BYTES) - pad0;
        pad_full = pad0;
        if (pad0 < 9'(HEADER_BYTES))
        begin
            pad_full = pad0 + ((need + amask) & ~amask);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg      <= op_t'(operation);
            req_reg     <= request_size;
            old_reg     <= current_size;
            blk_reg     <= block_offset;
            present_reg <= block_present;
            pad_reg     <= pad_full[PAD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        if (in_accept)
        begin
            hdr_rdata_reg <= hdr_mem[AW'(block_offset)];
        end
    end

    // execute
    logic [XW-1:0]    usable;
    logic [XW-1:0]    start;
    logic [XW-1:0]    alloc_end;
    logic             alloc_fail;
    logic [XW-1:0]    blk_x;
    logic [2:0]       check_st;
    logic [PAD_W-1:0] hdr_pad;
    logic [XW-1:0]    hdr_prev;
    logic [XW-1:0]    free_prev;
    logic             free_order;
    logic             do_alloc;
    logic             do_free;

    always_comb
    begin
        usable = (XW'(buffer_length_reg) > XW'(BUFFER_BYTES)) ?
                 XW'(BUFFER_BYTES) : XW'(buffer_length_reg);
        start      = top_reg + XW'(pad_reg);
        alloc_end  = start + XW'(req_reg);
        alloc_fail = (alloc_end > usable) || (start >= XW'(BUFFER_BYTES));

        blk_x = XW'(blk_reg);
        if (blk_x >= usable)
            check_st = ST_BOUNDS;
        else if (blk_x >= top_reg)
            check_st = ST_ABOVE;
        else
            check_st = ST_OK;

        hdr_pad    = hdr_rdata_reg[PAD_W-1:0];
        hdr_prev   = hdr_rdata_reg[HW-1:PAD_W];
        free_prev  = blk_x - XW'(hdr_pad);
        free_order = (XW'(hdr_pad) > blk_x) || (free_prev != prev_reg);

        status_next  = ST_OK;
        rvalid_next  = 1'b0;
        roffset_next = 12'd0;
        csrc_next    = 12'd0;
        clen_next    = 13'd0;
        do_alloc     = 1'b0;
        do_free      = 1'b0;

        case (op_reg)
            OP_ALLOC:
            begin
                do_alloc = 1'b1;
            end
            OP_RESIZE:
            begin
                if (!present_reg)
                    do_alloc = 1'b1;
                else if (req_reg == 13'd0)
                    do_free = 1'b1;
                else if (check_st != ST_OK)
                    status_next = check_st;
                else if (old_reg == req_reg)
                begin
                    rvalid_next  = 1'b1;
                    roffset_next = blk_reg;
                end
                else
                begin
                    do_alloc = 1'b1;
                    if (!alloc_fail)
                    begin
                        csrc_next = blk_reg;
                        clen_next = (old_reg < req_reg) ? old_reg : req_reg;
                    end
                end
            end
            OP_FREE:
            begin
                do_free = present_reg;
            end
            default:
            begin
            end
        endcase

        top_next  = top_reg;
        prev_next = prev_reg;
        hdr_we    = 1'b0;
        hdr_waddr = start[AW-1:0];
        hdr_wdata = {prev_reg, pad_reg};

        if (do_alloc)
        begin
            if (alloc_fail)
                status_next = ST_OOM;
            else
            begin
                rvalid_next  = 1'b1;
                roffset_next = start[11:0];
                hdr_we       = advance;
                if (advance)
                begin
                    prev_next = top_reg;
                    top_next  = alloc_end;
                end
            end
        end

        if (do_free)
        begin
            if (check_st != ST_OK)
                status_next = check_st;
            else if (free_order)
                status_next = ST_ORDER;
            else if (advance)
            begin
                top_next  = free_prev;
                prev_next = hdr_prev;
            end
        end

        if (advance && (op_reg == OP_FREE_ALL))
        begin
            top_next  = '0;
            prev_next = '0;
        end

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (advance)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            rvalid_reg  <= rvalid_next;
            roffset_reg <= roffset_next;
            csrc_reg    <= csrc_next;
            clen_reg    <= clen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_valid  = rvalid_reg;
    assign result_offset = roffset_reg;
    assign copy_source   = csrc_reg;
    assign copy_length   = clen_reg;

`ifndef ASSERT_OFF
    a_top_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= XW'(BUFFER_BYTES))
        else $error("top offset beyond buffer");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    a_hdr_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_we |=> (out_valid && (status == ST_OK) && result_valid))
        else $error("header written without successful alloc");

    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EXEC))
        else $error("result appeared outside execute");

    a_copy_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (copy_length != 13'd0)) |-> result_valid)
        else $error("copy request without returned block");
`endif

endmodule

### tb/stack_allocator_engine_top_tb.sv
// Testbench for the stack allocator engine: shadow stack model, random stalls, register phases.
`timescale 1ns / 1ps

module stack_allocator_engine_top_tb;
    import sae_pkg::*;

    localparam int unsigned BUF_BYTES    = 4096;
    localparam int unsigned HDR_BYTES    = 8;
    localparam int unsigned ALIGN_CAP    = 128;
    localparam int          N_PHASES     = 8;
    localparam int          PHASE_ITEMS  = 55;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_CYCLES = 400000;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    typedef struct packed {
        op_t         operation;
        logic [12:0] request_size;
        logic [12:0] current_size;
        logic [11:0] block_offset;
        logic        block_present;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        result_valid;
        logic [11:0] result_offset;
        logic [11:0] copy_source;
        logic [12:0] copy_length;
    } reply_t;

    typedef struct {
        int unsigned start;
        int unsigned bytes;
    } live_block_t;

    // Shadow copy of the allocator: registers, offsets, headers, expected replies.
    class stack_shadow;
        int unsigned buf_len    = 4096;
        int unsigned base_bits  = 0;
        int unsigned align_log2 = 4;
        int unsigned top        = 0;
        int unsigned prev       = 0;
        bit [20:0]   header [BUF_BYTES];
        bit          written [BUF_BYTES];
        int unsigned written_q[$];
        live_block_t live[$];
        reply_t      pending_replies[$];
        int          failures   = 0;

        function void set_register(logic [1:0] idx, logic [12:0] value);
            case (idx)
                CFG_BUFFER_LENGTH:  buf_len = value;
                CFG_BASE_LOW_BITS:  base_bits = value[6:0];
                CFG_ALIGNMENT_LOG2: align_log2 = value[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned usable();
            return (buf_len > BUF_BYTES) ? BUF_BYTES : buf_len;
        endfunction

        function int unsigned padding();
            int unsigned a, m, pad, need;
            a = 1 << align_log2;
            if (a > ALIGN_CAP)
                a = ALIGN_CAP;
            m = (base_bits + top) & (a - 1);
            pad = (m != 0) ? a - m : 0;
            if (pad < HDR_BYTES)
            begin
                need = HDR_BYTES - pad;
                pad += a * ((need + a - 1) / a);
            end
            return pad;
        endfunction

        function logic [2:0] try_alloc(int unsigned bytes, output int unsigned start);
            int unsigned pad, s;
            pad = padding();
            s = top + pad;
            start = s;
            if (s + bytes > usable() || s >= BUF_BYTES)
                return ST_OOM;
            header[s] = {prev[12:0], pad[7:0]};
            if (!written[s])
            begin
                written[s] = 1'b1;
                written_q.push_back(s);
            end
            prev = top;
            top = s + bytes;
            live.push_back('{s, bytes});
            return ST_OK;
        endfunction

        function logic [2:0] check_block(int unsigned blk);
            if (blk >= usable())
                return ST_BOUNDS;
            if (blk >= top)
                return ST_ABOVE;
            return ST_OK;
        endfunction

        function logic [2:0] release_block(int unsigned blk);
            logic [2:0]  st;
            bit [20:0]   h;
            int unsigned pad;
            st = check_block(blk);
            if (st != ST_OK)
                return st;
            h = header[blk];
            pad = h[7:0];
            if (pad > blk || blk - pad != prev)
                return ST_ORDER;
            top = blk - pad;
            prev = h[20:8];
            while (live.size() != 0 && live[$].start + live[$].bytes > top)
                void'(live.pop_back());
            return ST_OK;
        endfunction

        function reply_t predict(request_t r);
            reply_t      y;
            int unsigned s;
            y = '0;
            if (r.operation == OP_ALLOC || (r.operation == OP_RESIZE && !r.block_present))
            begin
                y.status = try_alloc(r.request_size, s);
                if (y.status == ST_OK)
                begin
                    y.result_valid = 1'b1;
                    y.result_offset = s[11:0];
                end
            end
            else if (r.operation == OP_RESIZE)
            begin
                if (r.request_size == 0)
                    y.status = release_block(r.block_offset);
                else
                begin
                    y.status = check_block(r.block_offset);
                    if (y.status == ST_OK && r.current_size == r.request_size)
                    begin
                        y.result_valid = 1'b1;
                        y.result_offset = r.block_offset;
                    end
                    else if (y.status == ST_OK)
                    begin
                        y.status = try_alloc(r.request_size, s);
                        if (y.status == ST_OK)
                        begin
                            y.result_valid = 1'b1;
                            y.result_offset = s[11:0];
                            y.copy_source = r.block_offset;
                            y.copy_length = (r.current_size < r.request_size) ?
                                            r.current_size : r.request_size;
                        end
                    end
                end
            end
            else if (r.operation == OP_FREE)
            begin
                if (r.block_present)
                    y.status = release_block(r.block_offset);
            end
            else
            begin
                top = 0;
                prev = 0;
                live.delete();
            end
            return y;
        endfunction

        function void note_request(request_t r);
            pending_replies.push_back(predict(r));
        endfunction

        function void compare_field(string name, logic [12:0] want, logic [12:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("reply with no transaction outstanding: status %0d offset %0d",
                       got.status, got.result_offset);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("result_valid", want.result_valid, got.result_valid);
            compare_field("result_offset", want.result_offset, got.result_offset);
            compare_field("copy_source", want.copy_source, got.copy_source);
            compare_field("copy_length", want.copy_length, got.copy_length);
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    op_t         operation;
    logic [12:0] request_size;
    logic [12:0] current_size;
    logic [11:0] block_offset;
    logic        block_present;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        result_valid;
    logic [11:0] result_offset;
    logic [11:0] copy_source;
    logic [12:0] copy_length;

    stack_shadow book = new();
    bit          hold_output = 1'b0;
    bit          quiet = 1'b0;
    int          cycles = 0;

    stack_allocator_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .request_size  (request_size),
        .current_size  (current_size),
        .block_offset  (block_offset),
        .block_present (block_present),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_valid  (result_valid),
        .result_offset (result_offset),
        .copy_source   (copy_source),
        .copy_length   (copy_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_reply(reply_t'({status, result_valid, result_offset,
                                       copy_source, copy_length}));
    end

    // Result side: random stall bursts, one long hold-off on request, none when quiet.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 20)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[12:0];
        do @(posedge clk); while (cfg_ready !== 1'b1);
        book.set_register(idx, value[12:0]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_request(input request_t r);
        in_valid      <= 1'b1;
        operation     <= r.operation;
        request_size  <= r.request_size;
        current_size  <= r.current_size;
        block_offset  <= r.block_offset;
        block_present <= r.block_present;
        do @(posedge clk); while (in_ready !== 1'b1);
        book.note_request(r);
    endtask

    task automatic post(input op_t op, input int unsigned req, input int unsigned cur,
                        input int unsigned blk, input bit present);
        request_t r;
        r.operation     = op;
        r.request_size  = req[12:0];
        r.current_size  = cur[12:0];
        r.block_offset  = blk[11:0];
        r.block_present = present;
        offer_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned rand_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 3)
            return 4096;
        if (p < 8)
            return $urandom_range(0, 4096);
        if (p < 30)
            return $urandom_range(0, 400);
        return $urandom_range(0, 64);
    endfunction

    // Offsets whose header would be read are either allocated ones or fail the
    // bounds/top check first, so an unwritten header is never looked at.
    function automatic int unsigned pick_block(input bit reads_header);
        int unsigned m, lim;
        m = $urandom_range(0, 9);
        lim = (book.usable() < book.top) ? book.usable() : book.top;
        if (book.live.size() != 0 && m < 5)
            return book.live[$].start;
        if (book.live.size() != 0 && m < 7)
            return book.live[$urandom_range(0, book.live.size() - 1)].start;
        if (book.written_q.size() != 0 && m < 8)
            return book.written_q[$urandom_range(0, book.written_q.size() - 1)];
        if (!reads_header)
            return $urandom_range(0, 4095);
        if (lim <= 4095)
            return $urandom_range(lim, 4095);
        return book.written_q[$urandom_range(0, book.written_q.size() - 1)];
    endfunction

    function automatic request_t random_request();
        request_t    r;
        live_block_t b;
        int unsigned pick;
        r.request_size  = 13'(rand_size());
        r.current_size  = 13'($urandom_range(0, 4096));
        r.block_offset  = 12'($urandom_range(0, 4095));
        r.block_present = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.operation = OP_FREE_ALL;
        else if (pick < 40)
            r.operation = OP_ALLOC;
        else if (pick < 68)
        begin
            r.operation     = OP_FREE;
            r.block_present = ($urandom_range(0, 15) != 0);
            r.block_offset  = 12'(pick_block(1'b1));
        end
        else
        begin
            r.operation     = OP_RESIZE;
            r.block_present = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                r.block_present = 1'b0;
            else if (pick < 4)
            begin
                r.request_size = 13'd0;
                r.block_offset = 12'(pick_block(1'b1));
            end
            else if (pick < 6 && book.live.size() != 0)
            begin
                b = book.live[$urandom_range(0, book.live.size() - 1)];
                r.block_offset = b.start[11:0];
                r.current_size = b.bytes[12:0];
                r.request_size = b.bytes[12:0];
            end
            else
            begin
                r.block_offset = 12'(pick_block(1'b0));
                if (r.request_size == 13'd0)
                    r.request_size = 13'd1;
            end
        end
        return r;
    endfunction

    task automatic run_directed();
        int unsigned a_off, c_off, d_off, e_off;
        post(OP_ALLOC, 0, 0, 0, 1'b0);
        a_off = book.live[$].start;
        post(OP_ALLOC, 4096, 4096, 4095, 1'b1);
        post(OP_ALLOC, 100, 0, 0, 1'b0);
        post(OP_ALLOC, 40, 0, 0, 1'b0);
        c_off = book.live[$].start;
        post(OP_FREE, 0, 0, a_off, 1'b1);            // not the newest block
        post(OP_FREE, 0, 0, book.top, 1'b1);         // at the top, ignored
        post(OP_FREE, 0, 0, 4095, 1'b0);             // null pointer
        post(OP_FREE, 0, 0, c_off, 1'b1);
        post(OP_RESIZE, 64, 0, 0, 1'b0);
        d_off = book.live[$].start;
        post(OP_RESIZE, 64, 64, d_off, 1'b1);
        post(OP_RESIZE, 200, 64, d_off, 1'b1);
        e_off = book.live[$].start;
        post(OP_RESIZE, 4096, 200, e_off, 1'b1);     // move that does not fit
        post(OP_RESIZE, 0, 200, e_off, 1'b1);
        post(OP_RESIZE, 5, 5, book.top, 1'b1);
        post(OP_FREE_ALL, 0, 0, 0, 1'b0);
        post(OP_ALLOC, 4064, 0, 0, 1'b0);
        post(OP_ALLOC, 0, 0, 0, 1'b0);               // aligned start lands on buffer end
        post(OP_FREE_ALL, 0, 0, 0, 1'b0);
        post(OP_ALLOC, 4080, 0, 0, 1'b0);            // exactly fills the buffer
        post(OP_RESIZE, 8, 4096, 4095, 1'b1);
        post(OP_FREE_ALL, 8191, 8191, 4095, 1'b1);
    endtask

    initial
    begin
        int          ph, i, gap_pct;
        int unsigned len, base, al;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_BUFFER_LENGTH;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        operation     <= OP_ALLOC;
        request_size  <= '0;
        current_size  <= '0;
        block_offset  <= '0;
        block_present <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:       begin len = 4096; base = 0;   al = 4; end
                1:       begin len = 8191; base = 127; al = 7; end
                2:       begin len = 1000; base = 33;  al = 3; end
                3:       begin len = 0;    base = 5;   al = 0; end
                4:       begin len = 4096; base = 127; al = 0; end
                5:       begin len = 300;  base = 64;  al = 2; end
                6:       begin
                             len  = $urandom_range(0, 4096);
                             base = $urandom_range(0, 127);
                             al   = $urandom_range(0, 7);
                         end
                default: begin len = 4096; base = 0;   al = 4; end
            endcase
            write_reg(CFG_BUFFER_LENGTH, len);
            write_reg(CFG_BASE_LOW_BITS, base);
            write_reg(CFG_ALIGNMENT_LOG2, al);
            if (ph == 3)
                write_reg(CFG_UNUSED, 32'h1FFF);
            quiet = (ph == N_PHASES - 1);
            gap_pct = quiet ? 0 : $urandom_range(5, 35);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == 20)
                    hold_output = 1'b1;
                if (ph == 4 && i == 25)
                begin
                    in_valid <= 1'b0;
                    while (book.pending() != 0) @(posedge clk);
                    @(posedge clk);
                end
                else if ($urandom_range(0, 99) < gap_pct)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                offer_request(random_request());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (book.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/sae_pkg.sv
rtl/stack_allocator_engine_top.sv
tb/stack_allocator_engine_top_tb.sv
